@@ sv/sgse_pkg.sv @@
// ----------------------------------------------------------------------------
// sgse_pkg
// Types, codes and helpers shared by the staggered grid stencil engine.
// ----------------------------------------------------------------------------
package sgse_pkg;

   localparam int VALUE_W = 32;
   localparam int IDX_W   = 6;
   localparam int CNT_W   = 6;
   localparam int INV_W   = 24;
   localparam int DIFF_W  = VALUE_W + 1;
   localparam int PROD_W  = DIFF_W + INV_W + 1;
   localparam int ACC_W   = VALUE_W + 11;
   localparam int CSR_W   = 3;

   typedef enum logic [1:0] {
      CMD_WR_X  = 2'd0,
      CMD_WR_Y  = 2'd1,
      CMD_WR_Z  = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

   localparam logic [CSR_W-1:0] CSR_CELLS_X = 3'd0;
   localparam logic [CSR_W-1:0] CSR_CELLS_Y = 3'd1;
   localparam logic [CSR_W-1:0] CSR_CELLS_Z = 3'd2;
   localparam logic [CSR_W-1:0] CSR_INV_X   = 3'd3;
   localparam logic [CSR_W-1:0] CSR_INV_Y   = 3'd4;
   localparam logic [CSR_W-1:0] CSR_INV_Z   = 3'd5;

   localparam logic [1:0] DST_DIV    = 2'd0;
   localparam logic [1:0] DST_CURL_X = 2'd1;
   localparam logic [1:0] DST_CURL_Y = 2'd2;
   localparam logic [1:0] DST_CURL_Z = 2'd3;

   typedef struct packed {
      cmd_type                    cmd;
      logic [IDX_W-1:0]           idx_i;
      logic [IDX_W-1:0]           idx_j;
      logic [IDX_W-1:0]           idx_k;
      logic signed [VALUE_W-1:0]  face_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  divergence;
      logic signed [VALUE_W-1:0]  center_x;
      logic signed [VALUE_W-1:0]  center_y;
      logic signed [VALUE_W-1:0]  center_z;
      logic signed [VALUE_W-1:0]  curl_x;
      logic signed [VALUE_W-1:0]  curl_y;
      logic signed [VALUE_W-1:0]  curl_z;
      logic                       index_error;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic       clear;
      logic       half;
      logic       neg;
      logic [1:0] dst;
   } mac_op_type;

   function automatic logic signed [VALUE_W-1:0] sat(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] vmax;
      logic signed [ACC_W-1:0] vmin;
      vmax = {{(ACC_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
      vmin = ~vmax;
      if (v > vmax) begin
         return {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (v < vmin) begin
         return {1'b1, {(VALUE_W-1){1'b0}}};
      end
      return v[VALUE_W-1:0];
   endfunction

endpackage

@@ sv/staggered_grid_stencil_engine.sv @@
// ----------------------------------------------------------------------------
// staggered_grid_stencil_engine
// Face velocity store of a staggered grid with divergence, center velocity
// and curl queries.
// ----------------------------------------------------------------------------
// A face write is written into its memory on acceptance and then passes
// the done state to the result register. A query makes ten reads from each
// of the three face memories through their single port (one word a cycle,
// registered read data), then nine products through one shared multiplier
// with a two-stage accumulate, then the result register. One transaction is
// in work at a time; a finished result waits in the output register while the next transaction is accepted.
module staggered_grid_stencil_engine #(
   parameter int MAX_CELLS_PER_AXIS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sgse_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sgse_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [sgse_pkg::CSR_W-1:0]    csr_index,
   input  logic [sgse_pkg::INV_W-1:0]    csr_wdata
);

   localparam int N     = MAX_CELLS_PER_AXIS;
   localparam int CW    = $clog2(N + 1);
   localparam int DEPTH = (N + 1) * N * N;
   localparam int AW    = $clog2(DEPTH);
   localparam int VW    = sgse_pkg::VALUE_W;
   localparam int DW    = sgse_pkg::DIFF_W;
   localparam int IW    = sgse_pkg::INV_W;
   localparam int CMPW  = ((CW > sgse_pkg::IDX_W) ? CW : sgse_pkg::IDX_W) + 1;

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_MUL, ST_DONE} state_type;

   function automatic logic [CW-1:0] clamp_n(input logic [sgse_pkg::CNT_W-1:0] c);
      if (c == '0) begin
         return CW'(1);
      end else if (CMPW'(c) > CMPW'(N)) begin
         return CW'(N);
      end
      return CW'(c);
   endfunction

   function automatic logic [AW-1:0] face_addr(input logic [CW-1:0] major,
                                                input logic [CW-1:0] a,
                                                input logic [CW-1:0] b);
      return (AW'(major) * AW'(N) + AW'(a)) * AW'(N) + AW'(b);
   endfunction

   // configuration
   logic [sgse_pkg::CNT_W-1:0] cells_x_ff, cells_y_ff, cells_z_ff;
   logic [IW-1:0]              inv_x_ff, inv_y_ff, inv_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff <= sgse_pkg::CNT_W'(32);
         cells_y_ff <= sgse_pkg::CNT_W'(32);
         cells_z_ff <= sgse_pkg::CNT_W'(32);
         inv_x_ff   <= IW'(65536);
         inv_y_ff   <= IW'(65536);
         inv_z_ff   <= IW'(65536);
      end else if (csr_we) begin
         case (csr_index)
            sgse_pkg::CSR_CELLS_X: cells_x_ff <= csr_wdata[sgse_pkg::CNT_W-1:0];
            sgse_pkg::CSR_CELLS_Y: cells_y_ff <= csr_wdata[sgse_pkg::CNT_W-1:0];
            sgse_pkg::CSR_CELLS_Z: cells_z_ff <= csr_wdata[sgse_pkg::CNT_W-1:0];
            sgse_pkg::CSR_INV_X:   inv_x_ff   <= csr_wdata;
            sgse_pkg::CSR_INV_Y:   inv_y_ff   <= csr_wdata;
            sgse_pkg::CSR_INV_Z:   inv_z_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [CW-1:0]   nx, ny, nz;
   logic [CMPW-1:0] nxw, nyw, nzw, iw, jw, kw;
   logic            x_ok, y_ok, z_ok, q_ok, wr_ok, accept;

   assign nx  = clamp_n(cells_x_ff);
   assign ny  = clamp_n(cells_y_ff);
   assign nz  = clamp_n(cells_z_ff);
   assign nxw = CMPW'(nx);
   assign nyw = CMPW'(ny);
   assign nzw = CMPW'(nz);
   assign iw  = CMPW'(req_data.idx_i);
   assign jw  = CMPW'(req_data.idx_j);
   assign kw  = CMPW'(req_data.idx_k);

   assign x_ok = (iw <= nxw) && (jw < nyw) && (kw < nzw);
   assign y_ok = (iw < nxw) && (jw <= nyw) && (kw < nzw);
   assign z_ok = (iw < nxw) && (jw < nyw) && (kw <= nzw);
   assign q_ok = (iw < nxw) && (jw < nyw) && (kw < nzw);

   always_comb begin
      case (req_data.cmd)
         sgse_pkg::CMD_WR_X: wr_ok = x_ok;
         sgse_pkg::CMD_WR_Y: wr_ok = y_ok;
         sgse_pkg::CMD_WR_Z: wr_ok = z_ok;
         default:            wr_ok = 1'b0;
      endcase
   end

   state_type  state_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // cell coordinates and clamped neighbors
   logic [CW-1:0] i_ff, j_ff, k_ff;
   logic [CW-1:0] id, iu, jd, ju, kd, ku;

   assign id = (i_ff == '0) ? i_ff : CW'(i_ff - 1'b1);
   assign jd = (j_ff == '0) ? j_ff : CW'(j_ff - 1'b1);
   assign kd = (k_ff == '0) ? k_ff : CW'(k_ff - 1'b1);
   assign iu = ((CMPW'(i_ff) + 1'b1) < nxw) ? CW'(i_ff + 1'b1) : i_ff;
   assign ju = ((CMPW'(j_ff) + 1'b1) < nyw) ? CW'(j_ff + 1'b1) : j_ff;
   assign ku = ((CMPW'(k_ff) + 1'b1) < nzw) ? CW'(k_ff + 1'b1) : k_ff;

   // read sequencing: step pairs give the two faces of one cell center
   logic [3:0]    step_ff;
   logic [2:0]    pair;
   logic [CW-1:0] sec;
   logic [CW-1:0] xi, xj, xk, yi, yj, yk, zi, zj, zk;
   logic [AW-1:0] addr_x, addr_y, addr_z;
   logic          we_x, we_y, we_z;
   logic [CW-1:0] wi, wj, wk;

   assign pair = step_ff[3:1];
   assign sec  = CW'(step_ff[0]);
   assign wi   = CW'(req_data.idx_i);
   assign wj   = CW'(req_data.idx_j);
   assign wk   = CW'(req_data.idx_k);

   always_comb begin
      xi = i_ff; xj = j_ff; xk = k_ff;
      yi = i_ff; yj = j_ff; yk = k_ff;
      zi = i_ff; zj = j_ff; zk = k_ff;
      case (pair)
         3'd1: begin
            xj = jd; yi = id; zi = id;
         end
         3'd2: begin
            xj = ju; yi = iu; zi = iu;
         end
         3'd3: begin
            xk = kd; yk = kd; zj = jd;
         end
         3'd4: begin
            xk = ku; yk = ku; zj = ju;
         end
         default: ;
      endcase
      if (state_ff == ST_IDLE) begin
         addr_x = face_addr(wi, wj, wk);
         addr_y = face_addr(wj, wi, wk);
         addr_z = face_addr(wk, wi, wj);
      end else begin
         addr_x = face_addr(CW'(xi + sec), xj, xk);
         addr_y = face_addr(CW'(yj + sec), yi, yk);
         addr_z = face_addr(CW'(zk + sec), zi, zj);
      end
   end

   assign we_x = accept && (req_data.cmd == sgse_pkg::CMD_WR_X) && x_ok;
   assign we_y = accept && (req_data.cmd == sgse_pkg::CMD_WR_Y) && y_ok;
   assign we_z = accept && (req_data.cmd == sgse_pkg::CMD_WR_Z) && z_ok;

   logic [VW-1:0] rd_x, rd_y, rd_z;

   sgse_ram #(.DEPTH(DEPTH), .AW(AW), .DW(VW)) u_ram_x (
      .clock(clock), .we(we_x), .addr(addr_x), .wdata(req_data.face_value), .rdata(rd_x));
   sgse_ram #(.DEPTH(DEPTH), .AW(AW), .DW(VW)) u_ram_y (
      .clock(clock), .we(we_y), .addr(addr_y), .wdata(req_data.face_value), .rdata(rd_y));
   sgse_ram #(.DEPTH(DEPTH), .AW(AW), .DW(VW)) u_ram_z (
      .clock(clock), .we(we_z), .addr(addr_z), .wdata(req_data.face_value), .rdata(rd_z));

   // read data capture: centers and own-cell differences
   logic                 rd_valid_ff;
   logic [3:0]           rd_step_ff;
   logic signed [VW-1:0] first_x_ff, first_y_ff, first_z_ff;
   logic signed [VW-1:0] cen_x_ff [5];
   logic signed [VW-1:0] cen_y_ff [5];
   logic signed [VW-1:0] cen_z_ff [5];
   logic signed [DW-1:0] dx_ff, dy_ff, dz_ff;
   logic signed [DW-1:0] sum_x, sum_y, sum_z;
   logic [2:0]           rd_pair;

   assign rd_pair = rd_step_ff[3:1];
   assign sum_x   = DW'($signed(rd_x)) + DW'(first_x_ff);
   assign sum_y   = DW'($signed(rd_y)) + DW'(first_y_ff);
   assign sum_z   = DW'($signed(rd_z)) + DW'(first_z_ff);

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         if (!rd_step_ff[0]) begin
            first_x_ff <= rd_x;
            first_y_ff <= rd_y;
            first_z_ff <= rd_z;
         end else begin
            cen_x_ff[rd_pair] <= sum_x[DW-1:1];
            cen_y_ff[rd_pair] <= sum_y[DW-1:1];
            cen_z_ff[rd_pair] <= sum_z[DW-1:1];
            if (rd_pair == 3'd0) begin
               dx_ff <= DW'($signed(rd_x)) - DW'(first_x_ff);
               dy_ff <= DW'($signed(rd_y)) - DW'(first_y_ff);
               dz_ff <= DW'($signed(rd_z)) - DW'(first_z_ff);
            end
         end
      end
   end

   // product schedule
   sgse_pkg::mac_op_type op;
   logic signed [DW-1:0] op_a;
   logic [IW-1:0]        op_b;
   logic signed [sgse_pkg::ACC_W-1:0] acc_div, acc_cx, acc_cy, acc_cz;

   always_comb begin
      op       = '0;
      op.clear = accept;
      op.valid = (state_ff == ST_MUL) && (step_ff < 4'd9);
      op.half  = 1'b1;
      op_a     = dx_ff;
      op_b     = inv_x_ff;
      case (step_ff)
         4'd0: begin
            op.half = 1'b0; op.dst = sgse_pkg::DST_DIV;
         end
         4'd1: begin
            op.half = 1'b0; op.dst = sgse_pkg::DST_DIV; op_a = dy_ff; op_b = inv_y_ff;
         end
         4'd2: begin
            op.half = 1'b0; op.dst = sgse_pkg::DST_DIV; op_a = dz_ff; op_b = inv_z_ff;
         end
         4'd3: begin
            op.dst = sgse_pkg::DST_CURL_X; op_b = inv_y_ff;
            op_a = DW'(cen_z_ff[4]) - DW'(cen_z_ff[3]);
         end
         4'd4: begin
            op.dst = sgse_pkg::DST_CURL_X; op.neg = 1'b1; op_b = inv_z_ff;
            op_a = DW'(cen_y_ff[4]) - DW'(cen_y_ff[3]);
         end
         4'd5: begin
            op.dst = sgse_pkg::DST_CURL_Y; op_b = inv_z_ff;
            op_a = DW'(cen_x_ff[4]) - DW'(cen_x_ff[3]);
         end
         4'd6: begin
            op.dst = sgse_pkg::DST_CURL_Y; op.neg = 1'b1; op_b = inv_x_ff;
            op_a = DW'(cen_z_ff[2]) - DW'(cen_z_ff[1]);
         end
         4'd7: begin
            op.dst = sgse_pkg::DST_CURL_Z; op_b = inv_x_ff;
            op_a = DW'(cen_y_ff[2]) - DW'(cen_y_ff[1]);
         end
         4'd8: begin
            op.dst = sgse_pkg::DST_CURL_Z; op.neg = 1'b1; op_b = inv_y_ff;
            op_a = DW'(cen_x_ff[2]) - DW'(cen_x_ff[1]);
         end
         default: ;
      endcase
   end

   sgse_mac u_mac (
      .clock(clock), .reset(reset), .op(op), .op_a(op_a), .op_b(op_b),
      .acc_div(acc_div), .acc_cx(acc_cx), .acc_cy(acc_cy), .acc_cz(acc_cz));

   // control
   state_type         state_in;
   logic [3:0]        step_in;
   logic              ok_ff, err_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   sgse_pkg::rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept) begin
               state_in = ((req_data.cmd == sgse_pkg::CMD_QUERY) && q_ok) ? ST_READ : ST_DONE;
            end
         end
         ST_READ: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd9) begin
               state_in = ST_MUL;
               step_in  = '0;
            end
         end
         ST_MUL: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd10) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.index_error = err_ff;
               if (ok_ff) begin
                  rsp_data_in.divergence = sgse_pkg::sat(acc_div);
                  rsp_data_in.center_x   = cen_x_ff[0];
                  rsp_data_in.center_y   = cen_y_ff[0];
                  rsp_data_in.center_z   = cen_z_ff[0];
                  rsp_data_in.curl_x     = sgse_pkg::sat(acc_cx);
                  rsp_data_in.curl_y     = sgse_pkg::sat(acc_cy);
                  rsp_data_in.curl_z     = sgse_pkg::sat(acc_cz);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rd_valid_ff  <= (state_ff == ST_READ);
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_step_ff  <= step_ff;
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         i_ff   <= CW'(req_data.idx_i);
         j_ff   <= CW'(req_data.idx_j);
         k_ff   <= CW'(req_data.idx_k);
         ok_ff  <= (req_data.cmd == sgse_pkg::CMD_QUERY) && q_ok;
         err_ff <= (req_data.cmd == sgse_pkg::CMD_QUERY) ? !q_ok : !wr_ok;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      (we_x || we_y || we_z) |-> (state_ff == ST_IDLE))
      else $error("face write outside idle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("ready high right after a transaction");

   a_mac_in_mul: assert property (@(posedge clock) disable iff (reset)
      op.valid |-> (state_ff == ST_MUL))
      else $error("product issued outside multiply phase");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result loaded outside done state");

endmodule

@@ sv/sgse_ram.sv @@
// ----------------------------------------------------------------------------
// sgse_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sgse_ram #(
   parameter int DEPTH = 33792,
   parameter int AW    = 16,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [DW-1:0] wdata,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/sgse_mac.sv @@
// ----------------------------------------------------------------------------
// sgse_mac
// Shared multiply unit: difference times reciprocal spacing, floor shift,
// accumulated into divergence and curl sums.
// ----------------------------------------------------------------------------
module sgse_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sgse_pkg::mac_op_type                  op,
   input  logic signed [sgse_pkg::DIFF_W-1:0]    op_a,
   input  logic [sgse_pkg::INV_W-1:0]            op_b,
   output logic signed [sgse_pkg::ACC_W-1:0]     acc_div,
   output logic signed [sgse_pkg::ACC_W-1:0]     acc_cx,
   output logic signed [sgse_pkg::ACC_W-1:0]     acc_cy,
   output logic signed [sgse_pkg::ACC_W-1:0]     acc_cz
);

   localparam int PW = sgse_pkg::PROD_W;
   localparam int AW = sgse_pkg::ACC_W;

   logic signed [PW-1:0]  prod_ff;
   logic signed [PW-1:0]  prod_in;
   sgse_pkg::mac_op_type  tag_ff;
   logic signed [PW-1:0]  shifted;
   logic signed [AW-1:0]  term;
   logic signed [AW-1:0]  acc_ff [4];

   always_comb begin
      prod_in = PW'(op_a) * $signed({1'b0, op_b});
      shifted = tag_ff.half ? (prod_ff >>> 17) : (prod_ff >>> 16);
      term    = AW'(shifted);
      if (tag_ff.neg) begin
         term = -term;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= op;
      end
      if (op.clear) begin
         for (int n = 0; n < 4; n++) begin
            acc_ff[n] <= '0;
         end
      end else if (tag_ff.valid) begin
         acc_ff[tag_ff.dst] <= acc_ff[tag_ff.dst] + term;
      end
   end

   assign acc_div = acc_ff[sgse_pkg::DST_DIV];
   assign acc_cx  = acc_ff[sgse_pkg::DST_CURL_X];
   assign acc_cy  = acc_ff[sgse_pkg::DST_CURL_Y];
   assign acc_cz  = acc_ff[sgse_pkg::DST_CURL_Z];

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      op.clear |-> !op.valid)
      else $error("mac clear together with an operation");

endmodule

@@ tb/sv/tb_staggered_grid_stencil_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_staggered_grid_stencil_engine
// Drives face writes and cell queries with random handshake gaps, predicts
// divergence, center velocity and curl, and checks every result in order.
// ----------------------------------------------------------------------------

class grid_scoreboard;
   localparam int AXN = 32;
   localparam int WORDS = (AXN + 1) * AXN * AXN;

   logic signed [sgse_pkg::VALUE_W-1:0] xf[WORDS];
   logic signed [sgse_pkg::VALUE_W-1:0] yf[WORDS];
   logic signed [sgse_pkg::VALUE_W-1:0] zf[WORDS];
   bit xw[WORDS];
   bit yw[WORDS];
   bit zw[WORDS];
   logic [sgse_pkg::CNT_W-1:0] cnt[3];
   logic [sgse_pkg::INV_W-1:0] inv[3];
   sgse_pkg::rsp_type expected_q[$];
   int errors;

   function new();
      cnt[0] = sgse_pkg::CNT_W'(32);
      cnt[1] = sgse_pkg::CNT_W'(32);
      cnt[2] = sgse_pkg::CNT_W'(32);
      inv[0] = sgse_pkg::INV_W'(65536);
      inv[1] = sgse_pkg::INV_W'(65536);
      inv[2] = sgse_pkg::INV_W'(65536);
      errors = 0;
   endfunction

   function int addr(int m, int a, int b);
      return ((m * AXN + a) * AXN + b) % WORDS;
   endfunction

   function int cells(int ax);
      if (cnt[ax] < 1) return 1;
      if (cnt[ax] > AXN) return AXN;
      return int'(cnt[ax]);
   endfunction

   function void write_reg(logic [sgse_pkg::CSR_W-1:0] idx, logic [sgse_pkg::INV_W-1:0] v);
      case (idx)
         sgse_pkg::CSR_CELLS_X: cnt[0] = v[sgse_pkg::CNT_W-1:0];
         sgse_pkg::CSR_CELLS_Y: cnt[1] = v[sgse_pkg::CNT_W-1:0];
         sgse_pkg::CSR_CELLS_Z: cnt[2] = v[sgse_pkg::CNT_W-1:0];
         sgse_pkg::CSR_INV_X:   inv[0] = v;
         sgse_pkg::CSR_INV_Y:   inv[1] = v;
         sgse_pkg::CSR_INV_Z:   inv[2] = v;
         default: ;
      endcase
   endfunction

   function longint rx(int i, int j, int k); return xf[addr(i, j, k)]; endfunction
   function longint ry(int i, int j, int k); return yf[addr(j, i, k)]; endfunction
   function longint rz(int i, int j, int k); return zf[addr(k, i, j)]; endfunction

   function void centre(int i, int j, int k, output longint c[3]);
      c[0] = (rx(i, j, k) + rx(i + 1, j, k)) >>> 1;
      c[1] = (ry(i, j, k) + ry(i, j + 1, k)) >>> 1;
      c[2] = (rz(i, j, k) + rz(i, j, k + 1)) >>> 1;
   endfunction

   function longint half_diff(longint hi, longint lo, int ax);
      return ((hi - lo) * longint'(inv[ax])) >>> 17;
   endfunction

   function logic signed [sgse_pkg::VALUE_W-1:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[sgse_pkg::VALUE_W-1:0];
   endfunction

   function void note(sgse_pkg::req_type r);
      sgse_pkg::rsp_type e;
      int i, j, k, nx, ny, nz;
      longint c[3], lf[3], rt[3], dn[3], up[3], bk[3], fr[3];
      longint d;
      e = '0;
      i = int'(r.idx_i); j = int'(r.idx_j); k = int'(r.idx_k);
      nx = cells(0); ny = cells(1); nz = cells(2);
      case (r.cmd)
         sgse_pkg::CMD_WR_X: if (i <= nx && j < ny && k < nz) begin
            xf[addr(i, j, k)] = r.face_value; xw[addr(i, j, k)] = 1;
         end else e.index_error = 1;
         sgse_pkg::CMD_WR_Y: if (i < nx && j <= ny && k < nz) begin
            yf[addr(j, i, k)] = r.face_value; yw[addr(j, i, k)] = 1;
         end else e.index_error = 1;
         sgse_pkg::CMD_WR_Z: if (i < nx && j < ny && k <= nz) begin
            zf[addr(k, i, j)] = r.face_value; zw[addr(k, i, j)] = 1;
         end else e.index_error = 1;
         default: if (i >= nx || j >= ny || k >= nz) begin
            e.index_error = 1;
         end else begin
            centre(i, j, k, c);
            d = (((rx(i + 1, j, k) - rx(i, j, k)) * longint'(inv[0])) >>> 16)
              + (((ry(i, j + 1, k) - ry(i, j, k)) * longint'(inv[1])) >>> 16)
              + (((rz(i, j, k + 1) - rz(i, j, k)) * longint'(inv[2])) >>> 16);
            e.divergence = sat32(d);
            e.center_x = c[0][sgse_pkg::VALUE_W-1:0];
            e.center_y = c[1][sgse_pkg::VALUE_W-1:0];
            e.center_z = c[2][sgse_pkg::VALUE_W-1:0];
            centre(i > 0 ? i - 1 : i, j, k, lf);
            centre(i + 1 < nx ? i + 1 : i, j, k, rt);
            centre(i, j > 0 ? j - 1 : j, k, dn);
            centre(i, j + 1 < ny ? j + 1 : j, k, up);
            centre(i, j, k > 0 ? k - 1 : k, bk);
            centre(i, j, k + 1 < nz ? k + 1 : k, fr);
            e.curl_x = sat32(half_diff(up[2], dn[2], 1) - half_diff(fr[1], bk[1], 2));
            e.curl_y = sat32(half_diff(fr[0], bk[0], 2) - half_diff(rt[2], lf[2], 0));
            e.curl_z = sat32(half_diff(rt[1], lf[1], 0) - half_diff(up[0], dn[0], 1));
         end
      endcase
      expected_q.push_back(e);
   endfunction

   function void check(sgse_pkg::rsp_type a);
      sgse_pkg::rsp_type e;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result %h", $time, a);
         errors++;
         return;
      end
      e = expected_q.pop_front();
      if (a.divergence !== e.divergence)
         $display("%0t: divergence exp %h got %h", $time, e.divergence, a.divergence);
      if (a.center_x !== e.center_x)
         $display("%0t: center_x exp %h got %h", $time, e.center_x, a.center_x);
      if (a.center_y !== e.center_y)
         $display("%0t: center_y exp %h got %h", $time, e.center_y, a.center_y);
      if (a.center_z !== e.center_z)
         $display("%0t: center_z exp %h got %h", $time, e.center_z, a.center_z);
      if (a.curl_x !== e.curl_x)
         $display("%0t: curl_x exp %h got %h", $time, e.curl_x, a.curl_x);
      if (a.curl_y !== e.curl_y)
         $display("%0t: curl_y exp %h got %h", $time, e.curl_y, a.curl_y);
      if (a.curl_z !== e.curl_z)
         $display("%0t: curl_z exp %h got %h", $time, e.curl_z, a.curl_z);
      if (a.index_error !== e.index_error)
         $display("%0t: index_error exp %b got %b", $time, e.index_error, a.index_error);
      if (a !== e) errors++;
   endfunction
endclass

module tb_staggered_grid_stencil_engine;
   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   sgse_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   sgse_pkg::rsp_type rsp_data;
   logic csr_we = 0;
   logic [sgse_pkg::CSR_W-1:0] csr_index = '0;
   logic [sgse_pkg::INV_W-1:0] csr_wdata = '0;

   grid_scoreboard grid = new();
   int sent = 0;
   bit quiet = 0;
   bit long_hold = 0;

   staggered_grid_stencil_engine dut (.*);

   always #6 clock = ~clock;

   task automatic send(sgse_pkg::cmd_type c, int i, int j, int k, logic [31:0] v);
      sgse_pkg::req_type r;
      int gap;
      r.cmd = c;
      r.idx_i = sgse_pkg::IDX_W'(i);
      r.idx_j = sgse_pkg::IDX_W'(j);
      r.idx_k = sgse_pkg::IDX_W'(k);
      r.face_value = v;
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      grid.note(r);
      sent++;
      gap = quiet ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 131071) - 65536;
         default: return $urandom;
      endcase
   endfunction

   // write every face of one cell that is still unknown
   task automatic fill_cell(int i, int j, int k);
      if (!grid.xw[grid.addr(i, j, k)])
         send(sgse_pkg::CMD_WR_X, i, j, k, rand_value());
      if (!grid.xw[grid.addr(i + 1, j, k)])
         send(sgse_pkg::CMD_WR_X, i + 1, j, k, rand_value());
      if (!grid.yw[grid.addr(j, i, k)])
         send(sgse_pkg::CMD_WR_Y, i, j, k, rand_value());
      if (!grid.yw[grid.addr(j + 1, i, k)])
         send(sgse_pkg::CMD_WR_Y, i, j + 1, k, rand_value());
      if (!grid.zw[grid.addr(k, i, j)])
         send(sgse_pkg::CMD_WR_Z, i, j, k, rand_value());
      if (!grid.zw[grid.addr(k + 1, i, j)])
         send(sgse_pkg::CMD_WR_Z, i, j, k + 1, rand_value());
   endtask

   task automatic query(int i, int j, int k);
      if (i < grid.cells(0) && j < grid.cells(1) && k < grid.cells(2)) begin
         fill_cell(i, j, k);
         fill_cell(i > 0 ? i - 1 : i, j, k);
         fill_cell(i + 1 < grid.cells(0) ? i + 1 : i, j, k);
         fill_cell(i, j > 0 ? j - 1 : j, k);
         fill_cell(i, j + 1 < grid.cells(1) ? j + 1 : j, k);
         fill_cell(i, j, k > 0 ? k - 1 : k);
         fill_cell(i, j, k + 1 < grid.cells(2) ? k + 1 : k);
      end
      send(sgse_pkg::CMD_QUERY, i, j, k, $urandom);
   endtask

   task automatic write_reg(logic [sgse_pkg::CSR_W-1:0] idx, logic [sgse_pkg::INV_W-1:0] v);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      grid.write_reg(idx, v);
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (grid.expected_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic setup(int cx, int cy, int cz, int ix, int iy, int iz);
      drain();
      write_reg(sgse_pkg::CSR_CELLS_X, sgse_pkg::INV_W'(cx));
      write_reg(sgse_pkg::CSR_CELLS_Y, sgse_pkg::INV_W'(cy));
      write_reg(sgse_pkg::CSR_CELLS_Z, sgse_pkg::INV_W'(cz));
      write_reg(sgse_pkg::CSR_INV_X, sgse_pkg::INV_W'(ix));
      write_reg(sgse_pkg::CSR_INV_Y, sgse_pkg::INV_W'(iy));
      write_reg(sgse_pkg::CSR_INV_Z, sgse_pkg::INV_W'(iz));
   endtask

   task automatic random_items(int budget);
      int stop, n[3], sel;
      stop = sent + budget;
      while (sent < stop) begin
         n[0] = grid.cells(0); n[1] = grid.cells(1); n[2] = grid.cells(2);
         sel = $urandom_range(0, 9);
         quiet = ($urandom_range(0, 7) == 0) ? ~quiet : quiet;
         if (sel < 4)
            query($urandom_range(0, n[0] - 1), $urandom_range(0, n[1] - 1),
                  $urandom_range(0, n[2] - 1));
         else if (sel == 4)
            query($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
         else if (sel < 9)
            send(sgse_pkg::cmd_type'($urandom_range(0, 2)), $urandom_range(0, n[0]),
                 $urandom_range(0, n[1]), $urandom_range(0, n[2]), rand_value());
         else
            send(sgse_pkg::cmd_type'($urandom_range(0, 2)), $urandom_range(0, 63),
                 $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      end
      quiet = 0;
   endtask

   initial begin
      int stall;
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 9);
         if (long_hold) begin
            stall = 400;
            long_hold = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         grid.check(rsp_data);
         @(negedge clock);
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, edges and out-of-range indexes, first at reset settings, then after setup changes
      send(sgse_pkg::CMD_WR_X, 32, 31, 31, 32'h7fffffff);
      send(sgse_pkg::CMD_WR_X, 33, 0, 0, 32'h1);
      send(sgse_pkg::CMD_WR_Y, 0, 33, 0, 32'h1);
      send(sgse_pkg::CMD_WR_Z, 0, 0, 33, 32'h1);
      send(sgse_pkg::CMD_WR_Y, 63, 63, 63, 32'hffffffff);
      send(sgse_pkg::CMD_QUERY, 32, 0, 0, '0);
      send(sgse_pkg::CMD_QUERY, 0, 63, 0, '0);
      query(0, 0, 0);
      query(31, 31, 31);
      setup(1, 1, 1, 24'hffffff, 24'hffffff, 24'hffffff);
      send(sgse_pkg::CMD_WR_X, 0, 0, 0, 32'h80000000);
      send(sgse_pkg::CMD_WR_X, 1, 0, 0, 32'h7fffffff);
      send(sgse_pkg::CMD_WR_Y, 0, 0, 0, 32'h80000000);
      send(sgse_pkg::CMD_WR_Y, 0, 1, 0, 32'h7fffffff);
      send(sgse_pkg::CMD_WR_Z, 0, 0, 0, 32'h80000000);
      send(sgse_pkg::CMD_WR_Z, 0, 0, 1, 32'h7fffffff);
      query(0, 0, 0);
      send(sgse_pkg::CMD_QUERY, 1, 0, 0, '0);
      setup(0, 63, 2, 0, 0, 0);
      query(0, 31, 1);
      query(0, 0, 0);

      random_items(250);
      setup(2, 3, 4, $urandom_range(1, 24'hffffff), 65536, 32768);
      long_hold = 1;
      random_items(300);
      setup(4, 4, 4, 24'hffffff, 1, $urandom_range(0, 24'hffffff));
      random_items(300);
      setup(3, 1, 5, 0, 24'hffffff, 65536);
      random_items(250);
      setup(32, 32, 32, $urandom_range(1, 24'hffff), $urandom_range(1, 24'hffff),
            $urandom_range(1, 24'hffffff));
      random_items(250);
      setup($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
            $urandom, $urandom, $urandom);
      random_items(250);

      drain();
      if (grid.errors == 0 && grid.expected_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #40ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule

@@ staggered_grid_stencil_engine.f @@
sv/sgse_pkg.sv
sv/sgse_ram.sv
sv/sgse_mac.sv
sv/staggered_grid_stencil_engine.sv
tb/sv/tb_staggered_grid_stencil_engine.sv
